>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros; compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: ante -> cons");

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante => cons");

`else

`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> design/bfea_pkg.sv
// ----------------------------------------------------------------------------
// bfea_pkg
// Shared types, constants and helpers for the 3x3 edge-average box filter.
// ----------------------------------------------------------------------------
package bfea_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int PIXEL_BITS = 8;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int WID_BITS   = COL_BITS + 1;
    localparam int ROW_BITS   = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int SUM_BITS   = PIXEL_BITS + 4;  // nine pixels
    localparam int RCP_BITS   = 17;              // 2^16 / count
    localparam int RCP_SHIFT  = 16;
    localparam int PROD_BITS  = SUM_BITS + RCP_BITS;

    // register indexes on the config port
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = CFG_IDX_BITS'(1);

    // results an input pixel at (r,c) may release, in output order
    typedef enum logic [1:0] {
        CAND_UP_LEFT = 2'd0,   // (r-1, c-1)
        CAND_UP      = 2'd1,   // (r-1, c)   last column
        CAND_LEFT    = 2'd2,   // (r,   c-1) last row
        CAND_HERE    = 2'd3    // (r,   c)   last row, last column
    } cand_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SUM,
        S_MUL,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic  accept;   // capture pixel, start line-store read
        logic  load;     // shift window, write line store, step position
        logic  sum;      // masked window sum for sel
        logic  mul;      // reciprocal multiply
        logic  emit;     // load output register
        cand_t sel;
    } cmd_t;

    typedef struct packed {
        logic       new_any;   // captured pixel releases at least one result
        logic [3:0] pending;   // results still to send
        logic       out_free;  // output register can take a result
    } status_t;

    // 2^16 / count rounded up; exact floor division for sums < 2^15
    function automatic logic [RCP_BITS-1:0] mean_recip(input logic [3:0] count);
        logic [RCP_BITS-1:0] r;
        begin
            case (count)
                4'd1:    r = RCP_BITS'(65536);
                4'd2:    r = RCP_BITS'(32768);
                4'd3:    r = RCP_BITS'(21846);
                4'd4:    r = RCP_BITS'(16384);
                4'd6:    r = RCP_BITS'(10923);
                4'd9:    r = RCP_BITS'(7282);
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

>>> design/box_filter_3x3_edge_average_unit.sv
// ----------------------------------------------------------------------------
// box_filter_3x3_edge_average_unit
// Streaming 3x3 mean filter with edge-aware averaging over a raster frame.
// ----------------------------------------------------------------------------
// Pixels come in one transfer at a time in raster order over a frame of
// frame_width x frame_height (config index 0 and 1; any write to either
// restarts the frame at row 0, column 0). Each result is the floor of the
// mean of the in-frame pixels of the 3x3 neighborhood, so the divisor is 1,
// 2, 3, 4, 6 or 9. A result leaves once the pixel below-right of it is in,
// so one input releases 0 to 4 results; run_last marks the last of them and
// frame_done the bottom-right pixel. Each input goes through capture with
// the line-store read and the window load, then per released result a
// masked sum, a reciprocal multiply and the output load, which waits while
// the output side stalls. The one sum/multiply unit walks the
// results in turn. The next pixel is taken while the last result still sits
// in the output register. Line stores are two MAX_WIDTH x 8 banks with no
// reset and no clearing pass: entries may be read before being written,
// but stale or unwritten ones are masked as outside the frame. cfg_ready is
// always high; config is to be written only while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module box_filter_3x3_edge_average_unit
    import bfea_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // config write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    // pixel input channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [PIXEL_BITS-1:0]    pixel_in,
    // result channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [PIXEL_BITS-1:0]    pixel_out,
    output logic [ROW_BITS-1:0]      out_row,
    output logic [COL_BITS-1:0]      out_col,
    output logic                     run_last,
    output logic                     frame_done
);

    cmd_t    cmd;
    status_t status;

    // sequencer: one pixel in flight, results walked one at a time through sum, multiply and emit
    bfea_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // storage, window, mean unit and output register
    bfea_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixel_in   (pixel_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_out  (pixel_out),
        .out_row    (out_row),
        .out_col    (out_col),
        .run_last   (run_last),
        .frame_done (frame_done),
        .cmd        (cmd),
        .status     (status)
    );

    // a result never overwrites one still waiting at the output
    `ASSERT_IMPLIES(a_emit_into_free, cmd.emit, status.out_free)
    // the bottom-right pixel is always the last result of its input
    `ASSERT_IMPLIES(a_done_is_last, out_valid && frame_done, run_last)
    // after a pixel transfer the window load cycle follows
    `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, cmd.load && !in_ready)
    // nothing left pending when the sequencer is back to taking pixels
    `ASSERT_IMPLIES(a_idle_empty, in_ready, status.pending == 4'd0)

endmodule

>>> design/bfea_ctrl.sv
// ----------------------------------------------------------------------------
// bfea_ctrl
// Sequencer: accepts one pixel, then walks its pending results one by one.
// ----------------------------------------------------------------------------
module bfea_ctrl
    import bfea_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    cand_t  first_sel;
    logic   more_left;

    // lowest pending result goes first
    always_comb
    begin
        if (status.pending[0])
            first_sel = CAND_UP_LEFT;
        else if (status.pending[1])
            first_sel = CAND_UP;
        else if (status.pending[2])
            first_sel = CAND_LEFT;
        else
            first_sel = CAND_HERE;
    end

    assign more_left = (status.pending & (status.pending - 4'd1)) != 4'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.sel    = first_sel;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = status.new_any ? S_SUM : S_IDLE;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = more_left ? S_SUM : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/bfea_datapath.sv
// ----------------------------------------------------------------------------
// bfea_datapath
// Config registers, frame position, line-store banks, 3x3 window,
// masked sum, reciprocal-multiply mean and output register.
// ----------------------------------------------------------------------------
module bfea_datapath
    import bfea_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // config
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    // input payload
    input  logic [PIXEL_BITS-1:0]    pixel_in,
    // output channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [PIXEL_BITS-1:0]    pixel_out,
    output logic [ROW_BITS-1:0]      out_row,
    output logic [COL_BITS-1:0]      out_col,
    output logic                     run_last,
    output logic                     frame_done,
    // control
    input  cmd_t                     cmd,
    output status_t                  status
);

    // config, stored already clamped
    logic [WID_BITS-1:0] width_reg;
    logic [ROW_BITS-1:0] height_reg;
    logic [WID_BITS-1:0] cfg_w;
    logic [COL_BITS-1:0] w_last;
    logic [ROW_BITS-1:0] h_last;

    // frame position of the next pixel
    logic [COL_BITS-1:0] col_pos_reg;
    logic [ROW_BITS-1:0] row_pos_reg;

    // captured item
    logic [PIXEL_BITS-1:0] pix_reg;
    logic [COL_BITS-1:0]   c_reg;
    logic [ROW_BITS-1:0]   r_reg;

    // line-store banks, selected by row parity
    logic [PIXEL_BITS-1:0] bank0_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] bank1_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] rd0_reg;
    logic [PIXEL_BITS-1:0] rd1_reg;

    // window[k][m]: rows r-2..r, cols c-2..c
    logic [PIXEL_BITS-1:0] win_reg [3][3];

    logic [3:0] cand;
    logic [3:0] pending_reg;
    cand_t      sel_reg;

    logic       r_ge1, r_ge2, c_ge1, c_ge2, r_last, c_last;
    logic       dr, dc, dr_held, dc_held;
    logic [2:0] row_ok, col_ok;
    logic [1:0] n_rows, n_cols;
    logic [3:0] count;
    logic [SUM_BITS-1:0] row_sum [3];
    logic [SUM_BITS-1:0] sum_next;

    logic [SUM_BITS-1:0]  sum_reg;
    logic [RCP_BITS-1:0]  rcp_reg;
    logic [PROD_BITS-1:0] prod_reg;

    logic                  out_valid_reg;
    logic [PIXEL_BITS-1:0] pixel_out_reg;
    logic [ROW_BITS-1:0]   out_row_reg;
    logic [COL_BITS-1:0]   out_col_reg;
    logic                  run_last_reg;
    logic                  frame_done_reg;
    logic [3:0]            pending_after;

    assign cfg_ready = 1'b1;

    // width from the low WID_BITS data bits: 0 acts as 1, above MAX_WIDTH as MAX_WIDTH
    always_comb
    begin
        cfg_w = cfg_data[WID_BITS-1:0];
        if (cfg_w == '0)
            cfg_w = WID_BITS'(1);
        else if (cfg_w > WID_BITS'(MAX_WIDTH))
            cfg_w = WID_BITS'(MAX_WIDTH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WID_BITS'(1024);
            height_reg <= ROW_BITS'(1024);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_w;
                REG_FRAME_HEIGHT: height_reg <= (cfg_data == '0) ? ROW_BITS'(1) : cfg_data;
                default: ;
            endcase
        end
    end

    assign w_last = COL_BITS'(width_reg - WID_BITS'(1));
    assign h_last = height_reg - ROW_BITS'(1);

    // position: any valid write to the width or height register restarts the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end
        else if (cfg_valid &&
                 (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT))
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end
        else if (cmd.load)
        begin
            if (c_last)
            begin
                col_pos_reg <= '0;
                row_pos_reg <= r_last ? '0 : r_reg + ROW_BITS'(1);
            end
            else
            begin
                col_pos_reg <= c_reg + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_reg <= pixel_in;
            c_reg   <= col_pos_reg;
            r_reg   <= row_pos_reg;
        end
    end

    // line store: read on accept, write back on load (read data first)
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd0_reg <= bank0_mem[col_pos_reg];
            rd1_reg <= bank1_mem[col_pos_reg];
        end
        if (cmd.load && !r_reg[0])
            bank0_mem[c_reg] <= pix_reg;
        if (cmd.load && r_reg[0])
            bank1_mem[c_reg] <= pix_reg;
    end

    // window shift; new column is {row r-2, row r-1, row r}
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
                for (int m = 0; m < 3; m++)
                    win_reg[k][m] <= '0;
        end
        else if (cmd.load)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k][0] <= win_reg[k][1];
                win_reg[k][1] <= win_reg[k][2];
            end
            win_reg[0][2] <= r_reg[0] ? rd1_reg : rd0_reg;
            win_reg[1][2] <= r_reg[0] ? rd0_reg : rd1_reg;
            win_reg[2][2] <= pix_reg;
        end
    end

    assign r_ge1  = r_reg != '0;
    assign r_ge2  = r_reg > ROW_BITS'(1);
    assign c_ge1  = c_reg != '0;
    assign c_ge2  = c_reg > COL_BITS'(1);
    assign r_last = r_reg == h_last;
    assign c_last = c_reg == w_last;

    assign cand[CAND_UP_LEFT] = r_ge1 && c_ge1;
    assign cand[CAND_UP]      = r_ge1 && c_last;
    assign cand[CAND_LEFT]    = r_last && c_ge1;
    assign cand[CAND_HERE]    = r_last && c_last;

    // mask of in-frame window rows/cols for the selected result
    assign dr = (cmd.sel == CAND_UP_LEFT) || (cmd.sel == CAND_UP);
    assign dc = (cmd.sel == CAND_UP_LEFT) || (cmd.sel == CAND_LEFT);
    assign row_ok = {1'b1, r_ge1, dr && r_ge2};
    assign col_ok = {1'b1, c_ge1, dc && c_ge2};
    assign n_rows = 2'd1 + {1'b0, row_ok[1]} + {1'b0, row_ok[0]};
    assign n_cols = 2'd1 + {1'b0, col_ok[1]} + {1'b0, col_ok[0]};
    assign count  = {2'b00, n_rows} * {2'b00, n_cols};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            row_sum[k] = '0;
            for (int m = 0; m < 3; m++)
                if (col_ok[m])
                    row_sum[k] = row_sum[k] + SUM_BITS'(win_reg[k][m]);
        end
        sum_next = '0;
        for (int k = 0; k < 3; k++)
            if (row_ok[k])
                sum_next = sum_next + row_sum[k];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            sum_reg <= sum_next;
            rcp_reg <= mean_recip(count);
            sel_reg <= cmd.sel;
        end
        if (cmd.mul)
            prod_reg <= PROD_BITS'(sum_reg) * PROD_BITS'(rcp_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else if (cmd.load)
            pending_reg <= cand;
        else if (cmd.emit)
            pending_reg <= pending_after;
    end

    assign pending_after = pending_reg & ~(4'd1 << sel_reg);
    assign dr_held = (sel_reg == CAND_UP_LEFT) || (sel_reg == CAND_UP);
    assign dc_held = (sel_reg == CAND_UP_LEFT) || (sel_reg == CAND_LEFT);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pixel_out_reg  <= prod_reg[RCP_SHIFT +: PIXEL_BITS];
            out_row_reg    <= r_reg - ROW_BITS'(dr_held);
            out_col_reg    <= c_reg - COL_BITS'(dc_held);
            run_last_reg   <= pending_after == 4'd0;
            frame_done_reg <= sel_reg == CAND_HERE;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_out_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign run_last   = run_last_reg;
    assign frame_done = frame_done_reg;

    assign status.new_any  = cand != 4'd0;
    assign status.pending  = pending_reg;
    assign status.out_free = !out_valid_reg || out_ready;

endmodule

>>> tb/sv/tb_box_filter_3x3_edge_average_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_box_filter_3x3_edge_average_unit
// Self-checking bench for the streaming 3x3 edge-aware mean filter.
// ----------------------------------------------------------------------------
// Pixels are streamed over many frame geometries: tiny frames, a clamped
// oversize width and a very tall narrow frame.
// A software copy of the filter (line stores, 3x3 window, raster position)
// predicts every smoothed pixel. Each output transfer is compared field by
// field with the oldest prediction. Both channels idle at random, and the
// output side holds off once for a long stretch so that the input stalls.
// ----------------------------------------------------------------------------

module tb_box_filter_3x3_edge_average_unit;

    import bfea_pkg::*;

    // ------------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------------
    // ignored register slots on the config port
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_2 = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_3 = CFG_IDX_BITS'(3);

    localparam int SETTLE_CYCLES = 20;    // margin for the worst item, one that releases four results
    localparam int HOLD_CYCLES   = 300;   // long output hold-off
    localparam int RANDOM_PIXELS = 360;

    // one smoothed pixel as it leaves the block
    typedef struct packed {
        logic [PIXEL_BITS-1:0] pix;
        logic [ROW_BITS-1:0]   row;
        logic [COL_BITS-1:0]   col;
        logic                  is_last;
        logic                  is_done;
    } smooth_t;

    typedef struct packed {
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [CFG_DATA_BITS-1:0] data;
    } cfg_write_t;

    typedef enum logic [1:0] {
        STEP_PIXEL,
        STEP_WRITE
    } step_kind_t;

    // one row of the directed stimulus table
    typedef struct packed {
        step_kind_t               kind;
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [CFG_DATA_BITS-1:0] data;
        logic [PIXEL_BITS-1:0]    pix;
        logic                     typed;   // want is the single result
        smooth_t                  want;
    } dir_step_t;

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [PIXEL_BITS-1:0]    pixel_in = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [PIXEL_BITS-1:0]    pixel_out;
    logic [ROW_BITS-1:0]      out_row;
    logic [COL_BITS-1:0]      out_col;
    logic                     run_last;
    logic                     frame_done;

    box_filter_3x3_edge_average_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel_in   (pixel_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_out  (pixel_out),
        .out_row    (out_row),
        .out_col    (out_col),
        .run_last   (run_last),
        .frame_done (frame_done)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    smooth_t    smoothed_due[$];     // predictions waiting for their transfer
    smooth_t    released[$];         // scratch: results of the last pixel
    cfg_write_t pending_writes[$];
    int         error_count = 0;
    int         pixels_accepted = 0;
    bit         no_idle = 1'b0;      // burst stretch: neither side idles
    bit         hold_done = 1'b0;
    smooth_t    front;

    // software filter state
    logic [PIXEL_BITS-1:0] line_mem [0:2*MAX_WIDTH-1];
    logic [PIXEL_BITS-1:0] win [0:2][0:2];   // rows r-2..r, cols c-2..c
    int unsigned           scan_col;
    int unsigned           scan_row;
    logic [WID_BITS-1:0]   cfg_width;
    logic [ROW_BITS-1:0]   cfg_height;

    // ------------------------------------------------------------------------
    // Directed table. Typed rows are 1x1 frames: the result is the pixel.
    // ------------------------------------------------------------------------
    localparam int N_DIRECTED = 32;
    dir_step_t directed [0:N_DIRECTED-1] = '{
        // right after reset (1024 x 1024): top row releases nothing
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h0000, 8'hFF, 1'b0, '0},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h0000, 8'h00, 1'b0, '0},
        // zero width and height act as 1: every pixel is its own mean
        '{STEP_WRITE, REG_FRAME_WIDTH,  16'h0000, 8'h00, 1'b0, '0},
        '{STEP_WRITE, REG_FRAME_HEIGHT, 16'h0000, 8'h00, 1'b0, '0},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h0000, 8'h00, 1'b1,
          '{8'h00, 16'd0, 10'd0, 1'b1, 1'b1}},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h0000, 8'hFF, 1'b1,
          '{8'hFF, 16'd0, 10'd0, 1'b1, 1'b1}},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h0000, 8'hAA, 1'b1,
          '{8'hAA, 16'd0, 10'd0, 1'b1, 1'b1}},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h0000, 8'h55, 1'b1,
          '{8'h55, 16'd0, 10'd0, 1'b1, 1'b1}},
        // 2x2: last pixel releases four results; writes to unused slots
        // in mid-frame must not restart it
        '{STEP_WRITE, REG_FRAME_WIDTH,  16'd2,    8'h00, 1'b0, '0},
        '{STEP_WRITE, REG_FRAME_HEIGHT, 16'd2,    8'h00, 1'b0, '0},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h0000, 8'hFF, 1'b0, '0},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h0000, 8'hFF, 1'b0, '0},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h0000, 8'hFF, 1'b0, '0},
        '{STEP_WRITE, REG_UNUSED_2,     16'hFFFF, 8'h00, 1'b0, '0},
        '{STEP_WRITE, REG_UNUSED_3,     16'h0001, 8'h00, 1'b0, '0},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h0000, 8'hFF, 1'b0, '0},
        // 3x3: divisors 4, 6 and 9
        '{STEP_WRITE, REG_FRAME_HEIGHT, 16'd3,    8'h00, 1'b0, '0},
        '{STEP_WRITE, REG_FRAME_WIDTH,  16'd3,    8'h00, 1'b0, '0},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h0000, 8'h00, 1'b0, '0},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h0000, 8'hFF, 1'b0, '0},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h0000, 8'h00, 1'b0, '0},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h0000, 8'hFF, 1'b0, '0},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h0000, 8'h80, 1'b0, '0},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h0000, 8'hFF, 1'b0, '0},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h0000, 8'h00, 1'b0, '0},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h0000, 8'hFF, 1'b0, '0},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h0000, 8'h01, 1'b0, '0},
        // one column of three: divisors 2 and 3
        '{STEP_WRITE, REG_FRAME_WIDTH,  16'd1,    8'h00, 1'b0, '0},
        '{STEP_WRITE, REG_FRAME_HEIGHT, 16'd3,    8'h00, 1'b0, '0},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h0000, 8'hFF, 1'b0, '0},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h0000, 8'h00, 1'b0, '0},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h0000, 8'hFE, 1'b0, '0}
    };

    // ------------------------------------------------------------------------
    // Software filter
    // ------------------------------------------------------------------------
    task automatic reset_filter();
        foreach (line_mem[k])
            line_mem[k] = '0;
        foreach (win[a, b])
            win[a][b] = '0;
        scan_col   = 0;
        scan_row   = 0;
        cfg_width  = WID_BITS'(MAX_WIDTH);
        cfg_height = ROW_BITS'(1024);
    endtask

    // any write to a real register restarts the frame; line data is kept
    task automatic apply_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT)
        begin
            if (idx == REG_FRAME_WIDTH)
                cfg_width = data[WID_BITS-1:0];
            else
                cfg_height = data[ROW_BITS-1:0];
            scan_col = 0;
            scan_row = 0;
        end
    endtask

    function automatic int unsigned active_width();
        int unsigned w;
        w = cfg_width;
        if (w == 0)
            w = 1;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned active_height();
        return (cfg_height == 0) ? 1 : cfg_height;
    endfunction

    // floor mean of in-frame neighbors of (i,j) with window anchored at (r,c)
    function automatic logic [PIXEL_BITS-1:0] neighborhood_mean(
        input int i, input int j, input int r, input int c,
        input int w, input int h);
        int unsigned sum;
        int unsigned cnt;
        int k;
        int m;
        sum = 0;
        cnt = 0;
        for (int a = i - 1; a <= i + 1; a++)
        begin
            for (int b = j - 1; b <= j + 1; b++)
            begin
                k = a - r + 2;
                m = b - c + 2;
                if (a >= 0 && a < h && b >= 0 && b < w
                    && k >= 0 && k <= 2 && m >= 0 && m <= 2)
                begin
                    sum += win[k][m];
                    cnt++;
                end
            end
        end
        return (cnt == 0) ? '0 : PIXEL_BITS'(sum / cnt);
    endfunction

    function automatic smooth_t make_result(input int i, input int j,
                                            input int r, input int c,
                                            input int w, input int h,
                                            input logic done);
        smooth_t s;
        s.pix     = neighborhood_mean(i, j, r, c, w, h);
        s.row     = ROW_BITS'(i);
        s.col     = COL_BITS'(j);
        s.is_last = 1'b0;
        s.is_done = done;
        return s;
    endfunction

    // advance the filter by one pixel; results land in released
    task automatic filter_pixel(input logic [PIXEL_BITS-1:0] p);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int unsigned old_bank;
        int unsigned prev_bank;
        w = active_width();
        h = active_height();
        if (scan_col >= w)
            scan_col = 0;
        if (scan_row >= h)
            scan_row = 0;
        r = scan_row;
        c = scan_col;

        for (int k = 0; k < 3; k++)
        begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        // bank r&1 still holds row r-2, the other bank row r-1
        old_bank  = (r & 1) * MAX_WIDTH;
        prev_bank = ((r + 1) & 1) * MAX_WIDTH;
        win[0][2] = line_mem[old_bank + c];
        win[1][2] = line_mem[prev_bank + c];
        win[2][2] = p;
        line_mem[old_bank + c] = p;

        released.delete();
        if (r >= 1)
        begin
            if (c >= 1)
                released.push_back(make_result(r - 1, c - 1, r, c, w, h, 1'b0));
            if (c == w - 1)
                released.push_back(make_result(r - 1, c, r, c, w, h, 1'b0));
        end
        if (r == h - 1)
        begin
            if (c >= 1)
                released.push_back(make_result(r, c - 1, r, c, w, h, 1'b0));
            if (c == w - 1)
                released.push_back(make_result(r, c, r, c, w, h, 1'b1));
        end
        if (released.size() > 0)
            released[released.size() - 1].is_last = 1'b1;

        if (c + 1 >= w)
        begin
            scan_col = 0;
            scan_row = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            scan_col = c + 1;
    endtask

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        error_count++;
        $display("ERROR @%0t: %s", $time, what);
    endtask

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                            : $urandom_range(1, 3);
    endfunction

    // extremes show up often, the rest is uniform
    function automatic logic [PIXEL_BITS-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIXEL_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one pixel and hold it until the transfer. valid stays high
    // after the transfer unless a gap follows; the next caller either
    // drives a new pixel or drops valid in the same step.
    task automatic send_pixel(input logic [PIXEL_BITS-1:0] p, input bit typed,
                              input smooth_t want);
        in_valid <= 1'b1;
        pixel_in <= p;
        do
            @(posedge clk);
        while (!in_ready);
        pixels_accepted++;
        filter_pixel(p);
        if (typed)
            smoothed_due.push_back(want);
        else
            foreach (released[k])
                smoothed_due.push_back(released[k]);
        if (!no_idle && $urandom_range(0, 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
    endtask

    // Drain before any register write. Pixels that release nothing leave
    // no trace in the queue, so allow the block's own latency on top.
    task automatic settle();
        in_valid <= 1'b0;
        while (smoothed_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // back-to-back config transfers from pending_writes
    task automatic program_registers();
        foreach (pending_writes[k])
        begin
            cfg_valid <= 1'b1;
            cfg_index <= pending_writes[k].idx;
            cfg_data  <= pending_writes[k].data;
            do
                @(posedge clk);
            while (!cfg_ready);
            apply_register(pending_writes[k].idx, pending_writes[k].data);
        end
        cfg_valid <= 1'b0;
        pending_writes.delete();
    endtask

    function automatic cfg_write_t unused_write();
        cfg_write_t cw;
        cw.idx  = $urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3;
        cw.data = CFG_DATA_BITS'($urandom);
        return cw;
    endfunction

    // one geometry, n_pix random pixels; sometimes an ignored write mid-frame
    task automatic stream_phase(input logic [CFG_DATA_BITS-1:0] w_data,
                                input logic [CFG_DATA_BITS-1:0] h_data,
                                input int n_pix);
        int split;
        split = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n_pix) : -1;
        if ($urandom_range(0, 1))
        begin
            pending_writes.push_back(cfg_write_t'{REG_FRAME_WIDTH, w_data});
            pending_writes.push_back(cfg_write_t'{REG_FRAME_HEIGHT, h_data});
        end
        else
        begin
            pending_writes.push_back(cfg_write_t'{REG_FRAME_HEIGHT, h_data});
            pending_writes.push_back(cfg_write_t'{REG_FRAME_WIDTH, w_data});
        end
        if ($urandom_range(0, 3) == 0)
            pending_writes.push_back(unused_write());
        settle();
        program_registers();
        for (int k = 0; k < n_pix; k++)
        begin
            if (k == split)
            begin
                settle();
                pending_writes.push_back(unused_write());
                program_registers();
            end
            send_pixel(rand_pixel(), 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stalls, burst stretches, and one long hold-off
    // taken while the sender is still offering pixels.
    // ------------------------------------------------------------------------
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (!hold_done && pixels_accepted >= 60 && out_valid && in_valid)
            begin
                out_ready <= 1'b0;
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (no_idle || $urandom_range(0, 2) != 0)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                repeat (gap_len()) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every output transfer against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (smoothed_due.size() == 0)
                report_mismatch($sformatf("unexpected result row %0d col %0d",
                                          out_row, out_col));
            else
            begin
                front = smoothed_due.pop_front();
                if (pixel_out !== front.pix)
                    report_mismatch($sformatf("pixel_out %0d, want %0d (row %0d col %0d)",
                                              pixel_out, front.pix, front.row, front.col));
                if (out_row !== front.row)
                    report_mismatch($sformatf("out_row %0d, want %0d",
                                              out_row, front.row));
                if (out_col !== front.col)
                    report_mismatch($sformatf("out_col %0d, want %0d (row %0d)",
                                              out_col, front.col, front.row));
                if (run_last !== front.is_last)
                    report_mismatch($sformatf("run_last %0b, want %0b (row %0d col %0d)",
                                              run_last, front.is_last, front.row,
                                              front.col));
                if (frame_done !== front.is_done)
                    report_mismatch($sformatf("frame_done %0b, want %0b (row %0d col %0d)",
                                              frame_done, front.is_done, front.row,
                                              front.col));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int          random_pixels;
        logic [CFG_DATA_BITS-1:0] w_data;
        logic [CFG_DATA_BITS-1:0] h_data;

        reset_filter();
        random_pixels = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed table; runs of writes go out together once idle
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (directed[i].kind == STEP_WRITE)
            begin
                pending_writes.push_back(cfg_write_t'{directed[i].idx, directed[i].data});
                if (i == N_DIRECTED - 1 || directed[i + 1].kind != STEP_WRITE)
                begin
                    settle();
                    program_registers();
                end
            end
            else
                send_pixel(directed[i].pix, directed[i].typed, directed[i].want);
        end

        // random geometries, mostly small; whole frames, repeats, partials
        while (random_pixels < RANDOM_PIXELS)
        begin
            w = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 40)
                                            : $urandom_range(1, 6);
            h = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 16)
                                            : $urandom_range(1, 5);
            w_data = CFG_DATA_BITS'(w);
            h_data = CFG_DATA_BITS'(h);
            if ($urandom_range(0, 9) == 0)
            begin
                w_data = '0;
                w = 1;
            end
            else if ($urandom_range(0, 7) == 0)
                // bits above the width register are dropped
                w_data[CFG_DATA_BITS-1:WID_BITS] = (CFG_DATA_BITS-WID_BITS)'($urandom);
            if ($urandom_range(0, 9) == 0)
            begin
                h_data = '0;
                h = 1;
            end
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, w * h)
                                            : w * h * $urandom_range(1, 2);
            if (n > RANDOM_PIXELS - random_pixels)
                n = RANDOM_PIXELS - random_pixels;
            no_idle = ($urandom_range(0, 3) == 0);
            stream_phase(w_data, h_data, n);
            random_pixels += n;
        end

        // clamped oversize width, partly streamed along the last row
        no_idle = 1'b0;
        stream_phase(16'hFFFF, 16'd1, 40);
        // tallest frame, partly streamed
        stream_phase(16'd1, 16'hFFFF, 30);

        settle();
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial
    begin
        #30_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
